FILE: rtl/lss_pkg.sv
// Shared types and constants for the Laplacian smoothing stencil.
package lss_pkg;

  localparam int ROW_W = 12;
  localparam int COUNT_W = 13;
  localparam int WEIGHT_W = 6;
  localparam int COLUMN_COUNT_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [COUNT_W-1:0] MIN_SIZE = 13'd3;
  localparam logic [COUNT_W-1:0] MAX_ROWS = 13'd4096;
  localparam logic [COUNT_W-1:0] ROW_COUNT_RESET = 13'd1024;
  localparam logic [COLUMN_COUNT_W-1:0] COLUMN_COUNT_RESET = 11'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WEIGHT       = 2'd0,
    REG_ROW_COUNT    = 2'd1,
    REG_COLUMN_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last_row;
    logic last_col;
  } lss_flags_t;

endpackage

FILE: rtl/lss_raster.sv
// Geometry registers, raster position counters and point classification.
module lss_raster #(
  parameter int MAX_COLUMNS = 1024,
  parameter int CW = $clog2(MAX_COLUMNS)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lss_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             advance,
  output logic [lss_pkg::ROW_W-1:0]        row,
  output logic [CW-1:0]                    column,
  output lss_pkg::lss_flags_t              flags,
  output logic signed [lss_pkg::WEIGHT_W-1:0] weight
);
  import lss_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_COLS = COUNT_W'(MAX_COLUMNS);

  logic [COUNT_W-1:0]        row_count;
  logic [COLUMN_COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0]        rows_eff;
  logic [COUNT_W-1:0]        cols_eff;
  logic [COUNT_W-1:0]        row_plus;
  logic [COUNT_W-1:0]        col_plus;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
      row_count <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_WEIGHT: weight <= $signed(cfg_data[WEIGHT_W-1:0]);
        REG_ROW_COUNT: row_count <= cfg_data[COUNT_W-1:0];
        REG_COLUMN_COUNT: column_count <= cfg_data[COLUMN_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_count < MIN_SIZE) rows_eff = MIN_SIZE;
    else if (row_count > MAX_ROWS) rows_eff = MAX_ROWS;
    else rows_eff = row_count;
    if (COUNT_W'(column_count) < MIN_SIZE) cols_eff = MIN_SIZE;
    else if (COUNT_W'(column_count) > MAX_COLS) cols_eff = MAX_COLS;
    else cols_eff = COUNT_W'(column_count);
    row_plus = COUNT_W'(row) + COUNT_W'(1);
    col_plus = COUNT_W'(column) + COUNT_W'(1);
    flags.emit = (row != '0);
    flags.last_col = (col_plus >= cols_eff);
    flags.last_row = (row_plus >= rows_eff);
    flags.interior = (row >= ROW_W'(2)) && (COUNT_W'(row) < rows_eff) &&
                     (column != '0) && !flags.last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      column <= '0;
    end else if (advance) begin
      if (flags.last_col) begin
        column <= '0;
        row <= flags.last_row ? '0 : row_plus[ROW_W-1:0];
      end else begin
        column <= col_plus[CW-1:0];
      end
    end
  end

  a_column_steps: assert property (@(posedge clk) disable iff (rst)
    advance && !flags.last_col |=> column == CW'($past(column) + CW'(1)))
    else $error("column position did not step by one");

endmodule

FILE: rtl/lss_line_buf.sv
// Two line buffers holding the previous and the older row of samples.
module lss_line_buf #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_WIDTH = 32,
  parameter int CW = $clog2(MAX_COLUMNS)
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [CW-1:0]                  rd_addr,
  input  logic [CW-1:0]                  rd_addr_right,
  output logic signed [SAMPLE_WIDTH-1:0] rd_up,
  output logic signed [SAMPLE_WIDTH-1:0] rd_center,
  output logic signed [SAMPLE_WIDTH-1:0] rd_right,
  input  logic                           wr_en,
  input  logic [CW-1:0]                  wr_addr,
  input  logic signed [SAMPLE_WIDTH-1:0] wr_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] wr_center
);

  logic [SAMPLE_WIDTH-1:0] older_mem [MAX_COLUMNS];
  logic [SAMPLE_WIDTH-1:0] prev_mem [MAX_COLUMNS];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_up <= $signed(older_mem[rd_addr]);
      rd_center <= $signed(prev_mem[rd_addr]);
      rd_right <= $signed(prev_mem[rd_addr_right]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr] <= wr_sample;
      older_mem[wr_addr] <= wr_center;
    end
  end

endmodule

FILE: rtl/lss_out_queue.sv
// Two-entry result register that holds the one or two results of an item.
module lss_out_queue #(
  parameter int CW = 10,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [lss_pkg::ROW_W-1:0]      a_row,
  input  logic [CW-1:0]                  a_col,
  input  logic signed [SAMPLE_WIDTH-1:0] a_value,
  input  logic                           b_valid,
  input  logic [lss_pkg::ROW_W-1:0]      b_row,
  input  logic signed [SAMPLE_WIDTH-1:0] b_value,
  input  logic                           b_end,
  input  logic                           pop,
  output logic                           ready,
  output logic                           head_valid,
  output logic [lss_pkg::ROW_W-1:0]      head_row,
  output logic [CW-1:0]                  head_col,
  output logic signed [SAMPLE_WIDTH-1:0] head_value,
  output logic                           head_end
);
  import lss_pkg::*;

  logic                           extra_valid;
  logic [ROW_W-1:0]               extra_row;
  logic [CW-1:0]                  extra_col;
  logic signed [SAMPLE_WIDTH-1:0] extra_value;
  logic                           extra_end;

  assign ready = !extra_valid && (!head_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      extra_valid <= 1'b0;
    end else if (push) begin
      head_valid <= 1'b1;
      extra_valid <= b_valid;
    end else if (pop) begin
      head_valid <= extra_valid;
      extra_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      head_row <= a_row;
      head_col <= a_col;
      head_value <= a_value;
      head_end <= 1'b0;
      extra_row <= b_row;
      extra_col <= a_col;
      extra_value <= b_value;
      extra_end <= b_end;
    end else if (pop) begin
      head_row <= extra_row;
      head_col <= extra_col;
      head_value <= extra_value;
      head_end <= extra_end;
    end
  end

  a_extra_behind_head: assert property (@(posedge clk) disable iff (rst)
    extra_valid |-> head_valid)
    else $error("second result held without a first");

  a_pair_kept: assert property (@(posedge clk) disable iff (rst)
    push && b_valid |=> extra_valid && head_valid)
    else $error("final-row result lost");

endmodule

FILE: rtl/laplacian_smoothing_stencil_top.sv
// Top level of the five-point Laplacian smoothing stencil.
//
// Samples enter in raster order, one item per cycle while in_stall is low; each interior
// point of the row above the incoming sample leaves as center + weight * (up + down +
// left + right - 4 * center), saturated, and border points pass through unchanged. Results
// run one row behind the input: the first row gives none, every other row gives one
// result per item, and the final row gives two (the point above, then the final-row
// point), so there the single result port holds the pipeline back while both leave. An
// item's first result is offered once the item has passed both stages: one stage holds
// the line buffer read and forms the Laplacian sum, and a second multiplies and saturates
// into a two-entry result register. The line buffers need no clearing after reset.
// Geometry and weight must be written only while idle; the block does not enforce this.
module laplacian_smoothing_stencil_top #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lss_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lss_pkg::ROW_W-1:0]           out_row,
  output logic [$clog2(MAX_COLUMNS)-1:0]      out_column,
  output logic signed [SAMPLE_WIDTH-1:0]      value,
  output logic                                frame_end
);
  import lss_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int SW = SAMPLE_WIDTH;

  logic                       in_accept;
  logic [ROW_W-1:0]           cur_row;
  logic [CW-1:0]              cur_col;
  lss_flags_t                 cur_flags;
  logic signed [WEIGHT_W-1:0] weight;

  logic                 s1_valid;
  logic                 s1_adv;
  logic signed [SW-1:0] s1_sample;
  logic [ROW_W-1:0]     s1_row;
  logic [CW-1:0]        s1_col;
  lss_flags_t           s1_flags;

  logic signed [SW-1:0] up_data;
  logic signed [SW-1:0] center_data;
  logic signed [SW-1:0] right_data;
  logic signed [SW-1:0] last_center;
  logic signed [SW+2:0] lap_next;

  logic                 s2_valid;
  logic                 s2_adv;
  logic signed [SW+2:0] s2_lap;
  logic signed [SW-1:0] s2_center;
  logic signed [SW-1:0] s2_sample;
  logic [ROW_W-1:0]     s2_row;
  logic [CW-1:0]        s2_col;
  lss_flags_t           s2_flags;

  logic signed [SW+9:0] smooth_sum;
  logic signed [SW-1:0] smooth_value;
  logic                 q_ready;

  assign in_accept = in_valid && !in_stall;
  assign s2_adv = s2_valid && (!s2_flags.emit || q_ready);
  assign s1_adv = s1_valid && (!s2_valid || s2_adv);
  assign in_stall = s1_valid && !s1_adv;

  lss_raster #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .CW(CW)
  ) u_raster (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .advance(in_accept),
    .row(cur_row),
    .column(cur_col),
    .flags(cur_flags),
    .weight(weight)
  );

  lss_line_buf #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .SAMPLE_WIDTH(SW),
    .CW(CW)
  ) u_line_buf (
    .clk(clk),
    .rd_en(in_accept),
    .rd_addr(cur_col),
    .rd_addr_right(cur_col + CW'(1)),
    .rd_up(up_data),
    .rd_center(center_data),
    .rd_right(right_data),
    .wr_en(s1_adv),
    .wr_addr(s1_col),
    .wr_sample(s1_sample),
    .wr_center(center_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_accept) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv) s2_valid <= 1'b1;
      else if (s2_adv) s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample <= sample;
      s1_row <= cur_row;
      s1_col <= cur_col;
      s1_flags <= cur_flags;
    end
  end

  // The left neighbor is the center of the item that went through just before.
  always_comb begin
    lap_next = (SW+3)'(up_data) + (SW+3)'(s1_sample) + (SW+3)'(last_center) +
               (SW+3)'(right_data) - ((SW+3)'(center_data) <<< 2);
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      last_center <= center_data;
      s2_lap <= lap_next;
      s2_center <= center_data;
      s2_sample <= s1_sample;
      s2_row <= s1_row;
      s2_col <= s1_col;
      s2_flags <= s1_flags;
    end
  end

  always_comb begin
    smooth_sum = (SW+10)'(s2_center) + (SW+10)'(weight) * (SW+10)'(s2_lap);
    if (!s2_flags.interior) begin
      smooth_value = s2_center;
    end else if ((smooth_sum[SW+9:SW-1] != '0) && (smooth_sum[SW+9:SW-1] != '1)) begin
      smooth_value = smooth_sum[SW+9] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      smooth_value = smooth_sum[SW-1:0];
    end
  end

  lss_out_queue #(
    .CW(CW),
    .SAMPLE_WIDTH(SW)
  ) u_out_queue (
    .clk(clk),
    .rst(rst),
    .push(s2_adv && s2_flags.emit),
    .a_row(s2_row - ROW_W'(1)),
    .a_col(s2_col),
    .a_value(smooth_value),
    .b_valid(s2_flags.last_row),
    .b_row(s2_row),
    .b_value(s2_sample),
    .b_end(s2_flags.last_col),
    .pop(out_valid && !out_stall),
    .ready(q_ready),
    .head_valid(out_valid),
    .head_row(out_row),
    .head_col(out_column),
    .head_value(value),
    .head_end(frame_end)
  );

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty first stage");

  a_no_line_buf_collision: assert property (@(posedge clk) disable iff (rst)
    in_accept && s1_adv |-> (cur_col != s1_col) && ((cur_col + CW'(1)) != s1_col))
    else $error("line buffer read and write at the same column");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the five-point Laplacian smoothing stencil top level.
`timescale 1ns / 1ps

module testbench;
  import lss_pkg::*;

  localparam int MAX_COLUMNS = 1024;
  localparam int SAMPLE_WIDTH = 32;
  localparam int COLUMN_W = $clog2(MAX_COLUMNS);
  localparam int QUIET_LIMIT = 2000;
  localparam int PIPE_SLACK = 8;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COLUMN_W-1:0] column;
    logic signed [SAMPLE_WIDTH-1:0] level;
    logic closes_frame;
  } grid_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROW_W-1:0] out_row;
  logic [COLUMN_W-1:0] out_column;
  logic signed [SAMPLE_WIDTH-1:0] value;
  logic frame_end;

  longint upper_line[MAX_COLUMNS];
  longint middle_line[MAX_COLUMNS];
  int unsigned next_row = 0;
  int unsigned next_column = 0;
  int smoothing_weight = 0;
  int unsigned rows_setting = ROW_COUNT_RESET;
  int unsigned columns_setting = COLUMN_COUNT_RESET;

  grid_point_t pending_points[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  laplacian_smoothing_stencil_top #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row(out_row),
    .out_column(out_column),
    .value(value),
    .frame_end(frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (upper_line[i]) begin
      upper_line[i] = 0;
      middle_line[i] = 0;
    end
  end

  function automatic int unsigned frame_rows();
    if (rows_setting < 3) return 3;
    if (rows_setting > 4096) return 4096;
    return rows_setting;
  endfunction

  function automatic int unsigned clamp_columns(input int unsigned setting);
    if (setting < 3) return 3;
    if (setting > MAX_COLUMNS) return MAX_COLUMNS;
    return setting;
  endfunction

  function automatic int unsigned frame_columns();
    return clamp_columns(columns_setting);
  endfunction

  // Finishes the point above the incoming item, and on the final row the item's own point.
  task automatic smooth_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    longint below;
    longint up_tap;
    longint left_tap;
    longint center_tap;
    longint right_tap;
    longint level;
    bit last_col;
    bit last_row;
    grid_point_t point;
    rows = frame_rows();
    cols = frame_columns();
    r = next_row;
    c = next_column;
    below = s;
    last_col = (c + 1 >= cols);
    last_row = (r + 1 >= rows);
    up_tap = upper_line[c];
    left_tap = (c > 0) ? upper_line[c - 1] : 0;
    center_tap = middle_line[c];
    right_tap = (c + 1 < MAX_COLUMNS) ? middle_line[c + 1] : 0;
    if (r >= 1) begin
      level = center_tap;
      if (r >= 2 && r < rows && c >= 1 && !last_col) begin
        level = center_tap + smoothing_weight *
                (up_tap + below + left_tap + right_tap - 4 * center_tap);
        if (level > longint'(SAMPLE_MAX)) begin
          level = SAMPLE_MAX;
        end else if (level < longint'(SAMPLE_MIN)) begin
          level = SAMPLE_MIN;
        end
      end
      point.row = ROW_W'(r - 1);
      point.column = COLUMN_W'(c);
      point.level = level[SAMPLE_WIDTH-1:0];
      point.closes_frame = 1'b0;
      pending_points.push_back(point);
      if (last_row) begin
        point.row = ROW_W'(r);
        point.level = s;
        point.closes_frame = last_col;
        pending_points.push_back(point);
      end
    end
    upper_line[c] = middle_line[c];
    middle_line[c] = below;
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    next_row = r;
    next_column = c;
  endtask

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic write_register(input cfg_reg_t which, input int setting);
    logic [CFG_DATA_W-1:0] data;
    data = setting[CFG_DATA_W-1:0];
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= data;
    case (which)
      REG_WEIGHT: smoothing_weight = int'($signed(data[WEIGHT_W-1:0]));
      REG_ROW_COUNT: rows_setting = data;
      REG_COLUMN_COUNT: columns_setting = data[COLUMN_COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      sample <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    smooth_sample(s);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2, 3: return $urandom;
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  // Two 3x3 frames whose single interior point saturates high, then low.
  task automatic test_directed_extremes();
    logic signed [SAMPLE_WIDTH-1:0] rising[9];
    logic signed [SAMPLE_WIDTH-1:0] falling[9];
    rising = '{0, SAMPLE_MAX, -1, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1, SAMPLE_MAX, SAMPLE_MIN};
    falling = '{SAMPLE_MAX, SAMPLE_MIN, 0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, -1, SAMPLE_MIN,
                SAMPLE_MAX};
    write_register(REG_COLUMN_COUNT, 3);
    write_register(REG_ROW_COUNT, 3);
    write_register(REG_WEIGHT, 1);
    foreach (rising[i]) send_sample(rising[i]);
    drain_results();
    write_register(REG_WEIGHT, 16);
    foreach (falling[i]) send_sample(falling[i]);
    drain_results();
  endtask

  // A frame started at full width, then cut to three columns and three rows mid-row.
  task automatic test_widest_rows();
    write_register(REG_COLUMN_COUNT, MAX_COLUMNS);
    write_register(REG_ROW_COUNT, 4096);
    write_register(REG_WEIGHT, 31);
    repeat (24) send_sample(pick_sample());
    drain_results();
    write_register(REG_COLUMN_COUNT, 0);
    write_register(REG_ROW_COUNT, 0);
    write_register(REG_WEIGHT, -32 & 'h3F);
    do begin
      send_sample(pick_sample());
    end while (next_row != 0 || next_column != 0);
    drain_results();
  endtask

  task automatic test_random_frames(input int sender_pct, input int receiver_pct,
                                    input int item_goal);
    int sent;
    int unsigned column_setting;
    sent = 0;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    while (sent < item_goal) begin
      drain_results();
      repeat ($urandom_range(3, 1)) begin
        case ($urandom_range(2))
          0: write_register(REG_WEIGHT, ($urandom_range(4) == 0) ? $urandom_range(63)
                                        : ($urandom_range(32) - 16) & 'h3F);
          1: case ($urandom_range(7))
               0: write_register(REG_ROW_COUNT, $urandom_range(2));
               1: write_register(REG_ROW_COUNT, $urandom_range(1) ? 8191
                                                : $urandom_range(8191, 7));
               default: write_register(REG_ROW_COUNT, $urandom_range(6, 3));
             endcase
          default: begin
            case ($urandom_range(7))
              0: column_setting = $urandom_range(2);
              1: column_setting = $urandom_range(1) ? 2047 : $urandom_range(2047, 9);
              default: column_setting = $urandom_range(8, 3);
            endcase
            // Rows only grow wider at the start of a frame, so every line buffer entry
            // that is read has been written.
            if ((next_row == 0 && next_column == 0) ||
                clamp_columns(column_setting) <= frame_columns()) begin
              write_register(REG_COLUMN_COUNT, int'(column_setting));
            end
          end
        endcase
      end
      if (frame_rows() * frame_columns() <= 64) begin
        do begin
          send_sample(pick_sample());
          sent++;
          if ($urandom_range(29) == 0) drain_results();
        end while (next_row != 0 || next_column != 0);
      end else begin
        repeat ($urandom_range(16, 4)) begin
          send_sample(pick_sample());
          sent++;
        end
      end
    end
    drain_results();
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    grid_point_t wanted;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        log_mismatch($sformatf("unexpected result row %0d column %0d value %0d",
                               out_row, out_column, value));
      end else begin
        wanted = pending_points.pop_front();
        if (out_row !== wanted.row || out_column !== wanted.column ||
            value !== wanted.level || frame_end !== wanted.closes_frame) begin
          log_mismatch($sformatf("got row %0d col %0d value %0d end %0b, want %0d %0d %0d %0b",
                                 out_row, out_column, value, frame_end, wanted.row,
                                 wanted.column, wanted.level, wanted.closes_frame));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 46;
    test_directed_extremes();
    test_widest_rows();
    test_random_frames(14, 46, 55);
    test_random_frames(46, 14, 55);
    test_random_frames(0, 0, 55);
    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
